// File: hw/rtl/tms_pkg.sv
// Shared types and constants for the single-tape Turing machine.
// Used by tms_match_cell and turing_machine_step_top. No dependencies.
package tms_pkg;

    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 8;
    localparam int TAPE_CELLS  = 256;

    localparam int STATE_W  = $clog2(MAX_STATES);
    localparam int SYM_W    = $clog2(MAX_SYMBOLS);
    localparam int HEAD_W   = $clog2(TAPE_CELLS);
    localparam int TBL_AW   = STATE_W + SYM_W;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 4;
    localparam int LIST_W   = 64;

    // item kinds
    localparam logic [2:0] K_LOAD_ENTRY = 3'd0;
    localparam logic [2:0] K_LOAD_CELL  = 3'd1;
    localparam logic [2:0] K_STEP       = 3'd2;
    localparam logic [2:0] K_READ_CELL  = 3'd3;
    localparam logic [2:0] K_RESTART    = 3'd4;

    // head moves
    localparam logic [1:0] MV_LEFT  = 2'd0;
    localparam logic [1:0] MV_RIGHT = 2'd1;
    localparam logic [1:0] MV_NONE  = 2'd2;
    localparam logic [1:0] MV_BAD   = 2'd3;

    // status codes
    localparam logic [2:0] ST_RUNNING    = 3'd0;
    localparam logic [2:0] ST_HALTED     = 3'd1;
    localparam logic [2:0] ST_LEFT_EDGE  = 3'd2;
    localparam logic [2:0] ST_BAD_MOVE   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;
    localparam logic [2:0] ST_RIGHT_EDGE = 3'd5;

    // configuration register indexes
    localparam logic CFG_SYMBOL_LIST  = 1'b0;
    localparam logic CFG_SYMBOL_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]        kind;
        logic [3:0]        state_index;
        logic [2:0]        symbol_index;
        logic [7:0]        cell_index;
        logic [7:0]        char_value;
        logic [1:0]        move_code;
        logic [3:0]        next_state;
        logic              halt_flag;
    } cmd_t;

    typedef struct packed {
        logic [3:0]        current_state;
        logic [7:0]        head_position;
        logic [2:0]        status_code;
        logic [7:0]        read_char;
    } res_t;

    typedef struct packed {
        logic              halt;
        logic [STATE_W-1:0] next;
        logic [1:0]        move;
        logic [CHAR_W-1:0] ch;
    } entry_t;

    // word passed from one match cell to the next
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
        logic              found;
        logic [SYM_W-1:0]  idx;
    } link_t;

endpackage

// File: hw/rtl/tms_match_cell.sv
// One cell of the symbol match chain: compares the passing character with one symbol.
// Depends on tms_pkg for link_t and widths.
module tms_match_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tms_pkg::link_t             up,
    input  logic [tms_pkg::CHAR_W-1:0] symbol,
    input  logic                       active,
    input  logic [tms_pkg::SYM_W-1:0]  cell_id,
    output tms_pkg::link_t             down
);

    logic                       valid_reg;
    logic [tms_pkg::CHAR_W-1:0] ch_reg;
    logic                       found_reg;
    logic [tms_pkg::SYM_W-1:0]  idx_reg;
    logic                       hit;

    // first match wins: a cell only claims the word if nothing upstream did
    assign hit = active && !up.found && (symbol == up.ch);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= up.ch;
        found_reg <= up.found | hit;
        idx_reg   <= hit ? cell_id : up.idx;
    end

    assign down.valid = valid_reg;
    assign down.ch    = ch_reg;
    assign down.found = found_reg;
    assign down.idx   = idx_reg;

endmodule

// File: hw/rtl/turing_machine_step_top.sv
// Single-tape Turing machine: control, tape and transition memories, match chain.
// Depends on tms_pkg and tms_match_cell.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   command  | cmd_valid / cmd_ready     | cmd (tms_pkg::cmd_t)
//   result   | res_valid / res_ready     | res (tms_pkg::res_t)
//   config   | cfg_write (no wait)       | cfg_index, cfg_data
//
// A step word goes from acceptance to a valid result through one tape read, the
// match chain, the table read as the word leaves the chain, the commit and the
// result load. An unknown symbol ends after the chain with no table read or
// commit; a stopped machine's step and every other kind go straight to the result
// load. One word is in work at a time: the next word is taken in the cycle after
// the result is loaded. Reset clears the tape at once through per-cell valid bits.
// A waiting result is held in the output register while the next word is taken;
// a second finished word waits for the output register and stalls the input.
module turing_machine_step_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  tms_pkg::cmd_t              cmd,
    output logic                       res_valid,
    input  logic                       res_ready,
    output tms_pkg::res_t              res,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [tms_pkg::LIST_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_MATCH = 3'd2;
    localparam logic [2:0] S_TABLE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [tms_pkg::STATE_W-1:0] mstate_reg, mstate_next;
    logic [tms_pkg::HEAD_W-1:0]  head_reg, head_next;
    logic [2:0]                  stop_reg, stop_next;
    tms_pkg::cmd_t               cmd_reg, cmd_next;
    tms_pkg::res_t               res_reg, res_next;
    logic                        res_valid_reg, res_valid_next;
    logic [tms_pkg::LIST_W-1:0]  sym_list_reg;
    logic [tms_pkg::CNT_W-1:0]   sym_cnt_reg;

    // transition memory, undefined until loaded
    tms_pkg::entry_t             tbl_mem [tms_pkg::MAX_STATES*tms_pkg::MAX_SYMBOLS];
    tms_pkg::entry_t             tbl_q;
    tms_pkg::entry_t             tbl_wdata;
    logic                        tbl_we, tbl_re;
    logic [tms_pkg::TBL_AW-1:0]  tbl_raddr;

    // tape memory with per-cell valid bits so reset reads back zero
    logic [tms_pkg::CHAR_W-1:0]  tape_mem [tms_pkg::TAPE_CELLS];
    logic [tms_pkg::TAPE_CELLS-1:0] tape_vld_reg;
    logic [tms_pkg::CHAR_W-1:0]  tape_q;
    logic                        tape_vld_q;
    logic                        tape_we, tape_re;
    logic [tms_pkg::HEAD_W-1:0]  tape_waddr, tape_raddr;
    logic [tms_pkg::CHAR_W-1:0]  tape_wdata, tape_char;

    tms_pkg::link_t              link [tms_pkg::MAX_SYMBOLS+1];
    tms_pkg::link_t              tail;
    logic                        inject;
    logic                        accept;

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign tape_char = tape_vld_q ? tape_q : '0;

    // ---------------- match chain ----------------
    assign link[0].valid = inject;
    assign link[0].ch    = tape_char;
    assign link[0].found = 1'b0;
    assign link[0].idx   = '0;
    assign tail          = link[tms_pkg::MAX_SYMBOLS];

    for (genvar i = 0; i < tms_pkg::MAX_SYMBOLS; i++)
    begin : g_cell
        logic active;
        assign active = (sym_cnt_reg > tms_pkg::CNT_W'(i));
        tms_match_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .up      (link[i]),
            .symbol  (sym_list_reg[tms_pkg::CHAR_W*i +: tms_pkg::CHAR_W]),
            .active  (active),
            .cell_id (tms_pkg::SYM_W'(i)),
            .down    (link[i+1])
        );
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_list_reg <= '0;
            sym_cnt_reg  <= tms_pkg::CNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tms_pkg::CFG_SYMBOL_LIST:  sym_list_reg <= cfg_data;
                tms_pkg::CFG_SYMBOL_COUNT: sym_cnt_reg  <= cfg_data[tms_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- memories ----------------
    assign tbl_wdata.halt = cmd.halt_flag;
    assign tbl_wdata.next = cmd.next_state;
    assign tbl_wdata.move = cmd.move_code;
    assign tbl_wdata.ch   = cmd.char_value;
    assign tbl_raddr      = {mstate_reg, tail.idx};

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[{cmd.state_index, cmd.symbol_index}] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_q <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        if (tape_re)
        begin
            tape_q <= tape_mem[tape_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tape_vld_reg <= '0;
            tape_vld_q   <= 1'b0;
        end
        else
        begin
            if (tape_we)
            begin
                tape_vld_reg[tape_waddr] <= 1'b1;
            end
            if (tape_re)
            begin
                tape_vld_q <= tape_vld_reg[tape_raddr];
            end
        end
    end

    // ---------------- control ----------------
    always_comb
    begin
        state_next     = state_reg;
        mstate_next    = mstate_reg;
        head_next      = head_reg;
        stop_next      = stop_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        tbl_we         = 1'b0;
        tbl_re         = 1'b0;
        tape_we        = 1'b0;
        tape_re        = 1'b0;
        tape_waddr     = '0;
        tape_wdata     = '0;
        tape_raddr     = '0;
        inject         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = S_DONE;
                    case (cmd.kind)
                        tms_pkg::K_LOAD_ENTRY:
                        begin
                            tbl_we = 1'b1;
                        end
                        tms_pkg::K_LOAD_CELL:
                        begin
                            tape_we    = 1'b1;
                            tape_waddr = cmd.cell_index;
                            tape_wdata = cmd.char_value;
                        end
                        tms_pkg::K_STEP:
                        begin
                            // a stopped machine ignores steps
                            if (stop_reg == tms_pkg::ST_RUNNING)
                            begin
                                tape_re    = 1'b1;
                                tape_raddr = head_reg;
                                state_next = S_FETCH;
                            end
                        end
                        tms_pkg::K_READ_CELL:
                        begin
                            tape_re    = 1'b1;
                            tape_raddr = cmd.cell_index;
                        end
                        tms_pkg::K_RESTART:
                        begin
                            mstate_next = '0;
                            head_next   = '0;
                            stop_next   = tms_pkg::ST_RUNNING;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH:
            begin
                inject     = 1'b1;
                state_next = S_MATCH;
            end
            S_MATCH:
            begin
                if (tail.valid)
                begin
                    if (!tail.found)
                    begin
                        stop_next  = tms_pkg::ST_UNKNOWN;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        tbl_re     = 1'b1;
                        state_next = S_TABLE;
                    end
                end
            end
            S_TABLE:
            begin
                // the character is written even when the move then faults
                tape_we    = 1'b1;
                tape_waddr = head_reg;
                tape_wdata = tbl_q.ch;
                state_next = S_DONE;
                case (tbl_q.move)
                    tms_pkg::MV_LEFT:
                    begin
                        if (head_reg == '0)
                        begin
                            stop_next = tms_pkg::ST_LEFT_EDGE;
                        end
                        else
                        begin
                            head_next = head_reg - tms_pkg::HEAD_W'(1);
                        end
                    end
                    tms_pkg::MV_RIGHT:
                    begin
                        if (head_reg == tms_pkg::HEAD_W'(tms_pkg::TAPE_CELLS - 1))
                        begin
                            stop_next = tms_pkg::ST_RIGHT_EDGE;
                        end
                        else
                        begin
                            head_next = head_reg + tms_pkg::HEAD_W'(1);
                        end
                    end
                    tms_pkg::MV_NONE: ;
                    default:
                    begin
                        stop_next = tms_pkg::ST_BAD_MOVE;
                    end
                endcase
                if ((tbl_q.move == tms_pkg::MV_LEFT && head_reg != '0) ||
                    (tbl_q.move == tms_pkg::MV_RIGHT &&
                     head_reg != tms_pkg::HEAD_W'(tms_pkg::TAPE_CELLS - 1)) ||
                    tbl_q.move == tms_pkg::MV_NONE)
                begin
                    if (tbl_q.halt)
                    begin
                        stop_next = tms_pkg::ST_HALTED;
                    end
                    else
                    begin
                        mstate_next = tbl_q.next;
                    end
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    res_next.current_state = mstate_reg;
                    res_next.head_position = head_reg;
                    res_next.status_code   = stop_reg;
                    res_next.read_char     = (cmd_reg.kind == tms_pkg::K_READ_CELL) ?
                                             tape_char : '0;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mstate_reg    <= '0;
            head_reg      <= '0;
            stop_reg      <= tms_pkg::ST_RUNNING;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mstate_reg    <= mstate_next;
            head_reg      <= head_next;
            stop_reg      <= stop_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    // ---------------- assertions ----------------
    a_tail_in_match: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == S_MATCH)
        else $error("match chain word arrived outside the match phase");

    a_stop_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg <= tms_pkg::ST_RIGHT_EDGE)
        else $error("status code out of range");

    a_stopped_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.kind == tms_pkg::K_STEP && stop_reg != tms_pkg::ST_RUNNING)
        |=> state_reg == S_DONE && $stable(head_reg) && $stable(stop_reg))
        else $error("step on a stopped machine changed the machine");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_TABLE && !(accept && cmd.kind == tms_pkg::K_RESTART))
        |=> $stable(head_reg))
        else $error("head moved outside a commit or restart");

endmodule
